// ----- rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and codes for the go-back-n send window.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;
	localparam logic [1:0] CMD_RSVD    = 2'd3;

	localparam logic [2:0] KIND_NEW     = 3'd0;
	localparam logic [2:0] KIND_RETX    = 3'd1;
	localparam logic [2:0] KIND_REFUSED = 3'd2;
	localparam logic [2:0] KIND_ACK_ADV = 3'd3;
	localparam logic [2:0] KIND_ACK_IGN = 3'd4;
	localparam logic [2:0] KIND_EMPTY   = 3'd5;

	localparam int LEN_W = 11;
	localparam int SEQ_W = 32;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [31:0]      ptr;
	} slot_t;

	typedef struct packed {
		logic [SEQ_W-1:0] a;
		logic [SEQ_W-1:0] b;
		logic             invert_b;
		logic             carry_in;
	} alu_req_t;

endpackage

// ----- rtl/gbn_if.sv -----
// ----------------------------------------------------------------------------
// gbn_cmd_if / gbn_res_if
// Valid/ready channels for command requests and window results.
// ----------------------------------------------------------------------------
interface gbn_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [10:0] chunk_length;
	logic [31:0] chunk_ref;
	logic [31:0] ack_number;

	modport source (output valid, command, chunk_length, chunk_ref, ack_number,
		input ready);
	modport sink (input valid, command, chunk_length, chunk_ref, ack_number,
		output ready);
endinterface

interface gbn_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [31:0] seq_number;
	logic [10:0] packet_length;
	logic [31:0] packet_ref;
	logic [3:0]  outstanding;
	logic        last;

	modport source (output valid, result_kind, seq_number, packet_length, packet_ref,
		outstanding, last, input ready);
	modport sink (input valid, result_kind, seq_number, packet_length, packet_ref,
		outstanding, last, output ready);
endinterface

// ----- rtl/gbn_alu.sv -----
// ----------------------------------------------------------------------------
// gbn_alu
// Shared 32-bit adder/subtractor for sequence number arithmetic.
// ----------------------------------------------------------------------------
module gbn_alu (
	input  gbn_pkg::alu_req_t           req,
	output logic [gbn_pkg::SEQ_W-1:0]   y
);

	logic [gbn_pkg::SEQ_W-1:0] b_eff;

	assign b_eff = req.invert_b ? ~req.b : req.b;
	assign y     = req.a + b_eff + gbn_pkg::SEQ_W'(req.carry_in);

endmodule

// ----- rtl/gbn_slot_mem.sv -----
// ----------------------------------------------------------------------------
// gbn_slot_mem
// Ring storage for held packets, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbn_slot_mem #(
	parameter int DEPTH = 8,
	parameter int IW    = 3
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  gbn_pkg::slot_t  wr_data,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output gbn_pkg::slot_t  rd_data
);

	gbn_pkg::slot_t mem_q [DEPTH];
	gbn_pkg::slot_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/go_back_n_send_window_top.sv -----
// ----------------------------------------------------------------------------
// go_back_n_send_window_top
// Go-back-n sender window: send, cumulative ack and timeout retransmit.
// ----------------------------------------------------------------------------
// Send: the result is registered in S_SEND once the output is free; ack runs
// S_ACK_DIST (distance), then S_ACK_APPLY (apply), both on the shared adder.
// Timeout: slot read, then emit, per held packet; an empty window emits from read.
// One request at a time; ready returns as the last result is registered, and a
// stalled result holds the sequencer.
// Reset clears the window and loads first_sequence = 1; slots need no clearing.
module go_back_n_send_window_top #(
	parameter int WINDOW_SLOTS = 8,
	parameter int MAX_CHUNK    = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	gbn_cmd_if.sink       cmd_ch,
	gbn_res_if.source     res_ch
);

	localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CW = $clog2(WINDOW_SLOTS + 1);
	localparam int SW = CW + 1;
	localparam logic [SW-1:0] SlotsW   = SW'(WINDOW_SLOTS);
	localparam logic [CW-1:0] FullCnt  = CW'(WINDOW_SLOTS);
	localparam logic [IW-1:0] LastIdx  = IW'(WINDOW_SLOTS - 1);
	localparam logic [16:0]   MaxChunk = 17'(MAX_CHUNK);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEND,
		S_ACK_DIST,
		S_ACK_APPLY,
		S_TO_RD,
		S_TO_EMIT
	} state_t;

	function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
		logic [SW-1:0] t;
		t = (s >= SlotsW) ? s - SlotsW : s;
		return t[IW-1:0];
	endfunction

	function automatic logic [3:0] cnt4(input logic [CW-1:0] c);
		logic [CW+3:0] t;
		t = (CW + 4)'(c);
		return t[3:0];
	endfunction

	state_t           state_q;
	logic [31:0]      base_q;
	logic [31:0]      next_q;
	logic [CW-1:0]    held_q;
	logic [IW-1:0]    head_q;
	logic [10:0]      len_q;
	logic [31:0]      ref_q;
	logic [31:0]      ack_q;
	logic [31:0]      dist_q;
	logic [31:0]      seq_q;
	logic [CW-1:0]    walk_q;
	logic [IW-1:0]    rd_idx_q;

	logic             res_valid_q;
	logic [2:0]       res_kind_q;
	logic [31:0]      res_seq_q;
	logic [10:0]      res_len_q;
	logic [31:0]      res_ref_q;
	logic [3:0]       res_out_q;
	logic             res_last_q;

	gbn_pkg::alu_req_t alu_req;
	logic [31:0]      alu_y;
	gbn_pkg::slot_t   wr_slot;
	gbn_pkg::slot_t   rd_slot;
	logic             mem_we;
	logic             mem_re;

	logic             accept;
	logic             out_free;
	logic             full;
	logic             ack_ok;
	logic             walk_last;
	logic [CW-1:0]    dist1;
	logic [IW-1:0]    send_pos;
	logic [IW-1:0]    ack_head;
	logic [10:0]      len_clip;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign out_free     = !res_valid_q || res_ch.ready;
	assign full         = (held_q >= FullCnt);
	assign ack_ok       = (held_q != '0) && (dist_q < 32'(held_q));
	assign dist1        = dist_q[CW-1:0] + CW'(1);
	assign send_pos     = wrap_idx(SW'(head_q) + SW'(held_q));
	assign ack_head     = wrap_idx(SW'(head_q) + SW'(dist1));
	assign walk_last    = ((SW'(walk_q) + SW'(1)) == SW'(held_q));
	assign len_clip     = (17'(cmd_ch.chunk_length) > MaxChunk) ? MaxChunk[10:0]
		: cmd_ch.chunk_length;

	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_SEND: begin
				alu_req.a        = next_q;
				alu_req.carry_in = 1'b1;
			end
			S_ACK_DIST: begin
				alu_req.a        = ack_q;
				alu_req.b        = base_q;
				alu_req.invert_b = 1'b1;
				alu_req.carry_in = 1'b1;
			end
			S_ACK_APPLY: begin
				alu_req.a        = base_q;
				alu_req.b        = dist_q;
				alu_req.carry_in = 1'b1;
			end
			S_TO_RD: begin
				alu_req.a = base_q;
				alu_req.b = 32'(walk_q);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	gbn_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign mem_we      = (state_q == S_SEND) && out_free && !full;
	assign mem_re      = (state_q == S_TO_RD) && (held_q != '0);
	assign wr_slot.len = len_q;
	assign wr_slot.ptr = ref_q;

	gbn_slot_mem #(
		.DEPTH (WINDOW_SLOTS),
		.IW    (IW)
	) u_slots (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (send_pos),
		.wr_data (wr_slot),
		.rd_en   (mem_re),
		.rd_addr (rd_idx_q),
		.rd_data (rd_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			base_q      <= 32'd1;
			next_q      <= 32'd1;
			held_q      <= '0;
			head_q      <= '0;
		end else begin
			if (res_valid_q && res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				base_q  <= cfg_wdata;
				next_q  <= cfg_wdata;
				held_q  <= '0;
				head_q  <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						len_q    <= len_clip;
						ref_q    <= cmd_ch.chunk_ref;
						ack_q    <= cmd_ch.ack_number;
						walk_q   <= '0;
						rd_idx_q <= head_q;
						unique case (cmd_ch.command)
							gbn_pkg::CMD_SEND:    state_q <= S_SEND;
							gbn_pkg::CMD_ACK:     state_q <= S_ACK_DIST;
							gbn_pkg::CMD_TIMEOUT: state_q <= S_TO_RD;
							default:              state_q <= S_IDLE;
						endcase
					end
				end
				S_SEND: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_seq_q   <= next_q;
						res_last_q  <= 1'b1;
						if (full) begin
							res_kind_q <= gbn_pkg::KIND_REFUSED;
							res_len_q  <= '0;
							res_ref_q  <= '0;
							res_out_q  <= cnt4(held_q);
						end else begin
							res_kind_q <= gbn_pkg::KIND_NEW;
							res_len_q  <= len_q;
							res_ref_q  <= ref_q;
							res_out_q  <= cnt4(held_q + CW'(1));
							next_q     <= alu_y;
							held_q     <= held_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_ACK_DIST: begin
					dist_q  <= alu_y;
					state_q <= S_ACK_APPLY;
				end
				S_ACK_APPLY: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_len_q   <= '0;
						res_ref_q   <= '0;
						res_last_q  <= 1'b1;
						if (ack_ok) begin
							res_kind_q <= gbn_pkg::KIND_ACK_ADV;
							res_seq_q  <= alu_y;
							res_out_q  <= cnt4(held_q - dist1);
							base_q     <= alu_y;
							head_q     <= ack_head;
							held_q     <= held_q - dist1;
						end else begin
							res_kind_q <= gbn_pkg::KIND_ACK_IGN;
							res_seq_q  <= base_q;
							res_out_q  <= cnt4(held_q);
						end
						state_q <= S_IDLE;
					end
				end
				S_TO_RD: begin
					if (held_q == '0) begin
						if (out_free) begin
							res_valid_q <= 1'b1;
							res_kind_q  <= gbn_pkg::KIND_EMPTY;
							res_seq_q   <= base_q;
							res_len_q   <= '0;
							res_ref_q   <= '0;
							res_out_q   <= '0;
							res_last_q  <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						seq_q   <= alu_y;
						state_q <= S_TO_EMIT;
					end
				end
				S_TO_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= gbn_pkg::KIND_RETX;
						res_seq_q   <= seq_q;
						res_len_q   <= rd_slot.len;
						res_ref_q   <= rd_slot.ptr;
						res_out_q   <= cnt4(held_q);
						res_last_q  <= walk_last;
						walk_q      <= walk_q + CW'(1);
						rd_idx_q    <= (rd_idx_q == LastIdx) ? '0 : rd_idx_q + IW'(1);
						state_q     <= walk_last ? S_IDLE : S_TO_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_ch.valid         = res_valid_q;
	assign res_ch.result_kind   = res_kind_q;
	assign res_ch.seq_number    = res_seq_q;
	assign res_ch.packet_length = res_len_q;
	assign res_ch.packet_ref    = res_ref_q;
	assign res_ch.outstanding   = res_out_q;
	assign res_ch.last          = res_last_q;

endmodule

// ----- rtl/gbn_checker.sv -----
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks for the go-back-n send window, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker #(
	parameter int WINDOW_SLOTS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  cmd_command,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_kind,
	input logic [3:0]  res_outstanding,
	input logic        res_last
);

	// result held while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind))
		else $error("result dropped or changed while stalled");

	// an accepted request other than the reserved code makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_command != gbn_pkg::CMD_RSVD) |=> !cmd_ready)
		else $error("request taken while previous one in flight");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == gbn_pkg::KIND_NEW || res_kind == gbn_pkg::KIND_REFUSED
		|| res_kind == gbn_pkg::KIND_ACK_ADV || res_kind == gbn_pkg::KIND_ACK_IGN)
		|-> res_last)
		else $error("single-result request without last");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == gbn_pkg::KIND_EMPTY) |-> res_last && (res_outstanding == 4'd0))
		else $error("empty timeout with packets held");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (WINDOW_SLOTS > 15) || (32'(res_outstanding) <= 32'(WINDOW_SLOTS)))
		else $error("outstanding count beyond window");

endmodule

bind go_back_n_send_window_top gbn_checker #(
	.WINDOW_SLOTS (WINDOW_SLOTS)
) u_gbn_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd_ch.valid),
	.cmd_ready       (cmd_ch.ready),
	.cmd_command     (cmd_ch.command),
	.res_valid       (res_ch.valid),
	.res_ready       (res_ch.ready),
	.res_kind        (res_ch.result_kind),
	.res_outstanding (res_ch.outstanding),
	.res_last        (res_ch.last)
);
